[sv/ccr_pkg.sv]
// shared types and constants of the contact concentration rate block
`default_nettype none
package ccr_pkg;
  localparam int INPUT_LANES = 4;
  localparam int DIV_STEPS   = 32;
  // input reg, product, sum, divider steps, rate multiply, rate output
  localparam int NSTAGE      = 3 + DIV_STEPS + 2;

  localparam logic [1:0] REG_NUM_MATERIALS = 2'd0;
  localparam logic [1:0] REG_THRESHOLD     = 2'd1;
  localparam logic [1:0] REG_INV_STEP      = 2'd2;

  localparam logic [47:0] POS_MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [48:0] NEG_MAG48 = 49'h0_8000_0000_0000;

  typedef logic [INPUT_LANES-1:0][31:0] lane_word_t;

  // what travels beside the divider
  typedef struct packed {
    logic                   inter;
    logic [INPUT_LANES-1:0] act;
    lane_word_t             conc;
    logic [33:0]            total;
  } side_t;
endpackage
`default_nettype wire

[sv/ccr_div_step.sv]
// one restoring division step of the mean divider, registered
`default_nettype none
module ccr_div_step (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [33:0] r_in,
  input  wire logic [31:0] lo_in,
  input  wire logic [31:0] q_in,
  input  wire logic [33:0] d,
  output logic      [33:0] r_out,
  output logic      [31:0] lo_out,
  output logic      [31:0] q_out
);
  logic [34:0] r2;
  logic [34:0] r_sub;
  logic        take;

  // shift in next numerator bit and try the subtract
  always_comb begin
    r2    = {r_in, lo_in[31]};
    r_sub = r2 - {1'b0, d};
    take  = (r2 >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out  <= take ? r_sub[33:0] : r2[33:0];
      lo_out <= {lo_in[30:0], 1'b0};
      q_out  <= {q_in[30:0], take};
    end
  end
endmodule
`default_nettype wire

[sv/ccr_rate_lane.sv]
// per-lane rate: (mean - conc) * inv_time_step >> 16, floored and saturated
`default_nettype none
module ccr_rate_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        keep,
  input  wire logic [31:0] mean,
  input  wire logic [31:0] conc,
  input  wire logic [31:0] inv_step,
  output logic      [47:0] rate
);
  import ccr_pkg::*;

  logic        neg;
  logic [63:0] mag;
  logic [31:0] diff;
  logic        neg_next;
  logic [47:0] q;
  logic [48:0] qn;
  logic [47:0] rate_next;

  // magnitude of the difference
  always_comb begin
    neg_next = keep && (conc > mean);
    if (!keep) diff = '0;
    else if (conc > mean) diff = conc - mean;
    else diff = mean - conc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg <= neg_next;
      mag <= diff * inv_step;
    end
  end

  // shift, floor for negatives, saturate to 48 bits
  always_comb begin
    q  = mag[63:16];
    qn = {1'b0, q} + {48'd0, (mag[15:0] != 16'd0)};
    if (qn > NEG_MAG48) qn = NEG_MAG48;
    if (!neg) begin
      rate_next = q[47] ? POS_MAX48 : q;
    end else begin
      rate_next = 48'd0 - qn[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) rate <= rate_next;
  end
endmodule
`default_nettype wire

[sv/contact_concentration_rate.sv]
// top level: lanes, product merge, mean divider and rate lanes
// Usage:
//   Input channel in_valid/in_ready carries one grid node per item: four
//   volumes and four concentrations. Output channel out_valid/out_ready
//   carries one result item per node: is_interface and four 48-bit rates.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle, which the block does not enforce.
// Pipeline: input register, product, product sum and interface test, 32
//   one-bit divider stages for the volume-weighted mean, rate multiply,
//   rate round and saturate.
// Throughput: one item per cycle, a new node every cycle while not stalled.
// Stall: when out_valid is high and out_ready low the whole pipeline
//   holds and in_ready drops; in_ready is high whenever the output register
//   is empty or being taken.
// Reset: rst clears all valid bits and loads num_materials=2,
//   volume_threshold=1, inv_time_step=1.0 (Q16.16).
`default_nettype none
module contact_concentration_rate #(
  parameter int MATERIAL_LANES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [31:0] volume_a,
  input  wire logic        [31:0] volume_b,
  input  wire logic        [31:0] volume_c,
  input  wire logic        [31:0] volume_d,
  input  wire logic        [31:0] conc_a,
  input  wire logic        [31:0] conc_b,
  input  wire logic        [31:0] conc_c,
  input  wire logic        [31:0] conc_d,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    is_interface,
  output logic signed      [47:0] rate_a,
  output logic signed      [47:0] rate_b,
  output logic signed      [47:0] rate_c,
  output logic signed      [47:0] rate_d,
  input  wire logic               cfg_write,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);
  import ccr_pkg::*;

  logic [2:0]  num_materials;
  logic [31:0] volume_threshold;
  logic [31:0] inv_time_step;

  logic [NSTAGE-1:0] vpipe;
  logic              adv;

  lane_word_t vol_in, conc_in;
  logic [INPUT_LANES-1:0] act_in;

  lane_word_t vol1, conc1;
  logic [INPUT_LANES-1:0] act1;

  logic [INPUT_LANES-1:0][63:0] prod2;
  lane_word_t vol2, conc2;
  logic [INPUT_LANES-1:0] act2;
  logic [33:0] total2;

  logic [65:0] num3;
  side_t       side3;
  logic [65:0] num_sum;
  logic        inter_next;

  logic [DIV_STEPS-1:0][33:0] rq;
  logic [DIV_STEPS-1:0][31:0] loq;
  logic [DIV_STEPS-1:0][31:0] qq;
  side_t side_q [DIV_STEPS];

  logic inter_a;
  logic [INPUT_LANES-1:0][47:0] rate_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_materials    <= 3'd2;
      volume_threshold <= 32'd1;
      inv_time_step    <= 32'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_MATERIALS: num_materials    <= cfg_data[2:0];
        REG_THRESHOLD:     volume_threshold <= cfg_data;
        REG_INV_STEP:      inv_time_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  assign adv       = !vpipe[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vpipe[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (adv) vpipe <= {vpipe[NSTAGE-2:0], in_valid};
  end

  assign vol_in  = {volume_d, volume_c, volume_b, volume_a};
  assign conc_in = {conc_d, conc_c, conc_b, conc_a};

  // active lanes
  for (genvar i = 0; i < INPUT_LANES; i++) begin : g_act
    assign act_in[i] = (i < MATERIAL_LANES) && (num_materials > 3'(i));
  end

  // input register, inactive volumes zeroed
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < INPUT_LANES; i++) begin
        vol1[i] <= act_in[i] ? vol_in[i] : 32'd0;
      end
      conc1 <= conc_in;
      act1  <= act_in;
    end
  end

  // lane products and total volume
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < INPUT_LANES; i++) begin
        prod2[i] <= vol1[i] * conc1[i];
      end
      total2 <= 34'(vol1[0]) + 34'(vol1[1]) + 34'(vol1[2]) + 34'(vol1[3]);
      vol2   <= vol1;
      conc2  <= conc1;
      act2   <= act1;
    end
  end

  // merge: product sum and interface test
  always_comb begin
    num_sum    = '0;
    inter_next = 1'b0;
    for (int i = 0; i < INPUT_LANES; i++) begin
      num_sum = num_sum + 66'(prod2[i]);
      if (act2[i] && vol2[i] > volume_threshold && 34'(vol2[i]) != total2)
        inter_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num3        <= num_sum;
      side3.inter <= inter_next;
      side3.act   <= act2;
      side3.conc  <= conc2;
      side3.total <= total2;
    end
  end

  // mean divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    if (k == 0) begin : g_first
      ccr_div_step u_step (
        .clk(clk), .en(adv),
        .r_in(num3[65:32]), .lo_in(num3[31:0]), .q_in(32'd0),
        .d(side3.total),
        .r_out(rq[k]), .lo_out(loq[k]), .q_out(qq[k])
      );
      always_ff @(posedge clk) begin
        if (adv) side_q[k] <= side3;
      end
    end else begin : g_rest
      ccr_div_step u_step (
        .clk(clk), .en(adv),
        .r_in(rq[k-1]), .lo_in(loq[k-1]), .q_in(qq[k-1]),
        .d(side_q[k-1].total),
        .r_out(rq[k]), .lo_out(loq[k]), .q_out(qq[k])
      );
      always_ff @(posedge clk) begin
        if (adv) side_q[k] <= side_q[k-1];
      end
    end
  end

  // rate lanes
  for (genvar i = 0; i < INPUT_LANES; i++) begin : g_lane
    ccr_rate_lane u_lane (
      .clk(clk), .en(adv),
      .keep(side_q[DIV_STEPS-1].inter && side_q[DIV_STEPS-1].act[i]),
      .mean(qq[DIV_STEPS-1]),
      .conc(side_q[DIV_STEPS-1].conc[i]),
      .inv_step(inv_time_step),
      .rate(rate_w[i])
    );
  end

  // interface flag follows the rate lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      inter_a      <= side_q[DIV_STEPS-1].inter;
      is_interface <= inter_a;
    end
  end

  assign rate_a = rate_w[0];
  assign rate_b = rate_w[1];
  assign rate_c = rate_w[2];
  assign rate_d = rate_w[3];
endmodule
`default_nettype wire

[sv/ccr_checker.sv]
// port-level checks of the contact concentration rate block, with bind
`default_nettype none
module ccr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_interface,
  input wire logic [47:0] rate_a,
  input wire logic [47:0] rate_b,
  input wire logic [47:0] rate_c,
  input wire logic [47:0] rate_d
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rate_a) && $stable(rate_b)
      && $stable(rate_c) && $stable(rate_d) && $stable(is_interface))
    else $error("held item changed");

  // output empty after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item after reset");

  // non-interface nodes carry zero rates
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_interface |-> rate_a == 48'd0 && rate_b == 48'd0
      && rate_c == 48'd0 && rate_d == 48'd0)
    else $error("rate on non-interface node");

  // a stalled output blocks the input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while stalled");
endmodule

bind contact_concentration_rate ccr_checker u_ccr_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .is_interface(is_interface), .rate_a(rate_a),
  .rate_b(rate_b), .rate_c(rate_c), .rate_d(rate_d)
);
`default_nettype wire

[tb/contact_concentration_rate_test.sv]
// testbench for the contact concentration rate block: scoreboard and stimulus
`timescale 1ns / 1ps
`default_nettype none

class rate_scoreboard;
  logic [2:0]  num_mat;
  logic [31:0] thresh;
  logic [31:0] inv_step;
  logic [192:0] pending_rates[$];
  int errors;

  function new();
    num_mat = 3'd2;
    thresh = 32'd1;
    inv_step = 32'd65536;
    errors = 0;
  endfunction

  // floor((mean - conc) * inv >> 16), saturated to 48 bits
  function logic [47:0] lane_rate(logic [31:0] mean, logic [31:0] conc);
    logic signed [33:0] diff;
    logic signed [66:0] prod;
    logic signed [66:0] q;
    diff = $signed({2'b00, mean}) - $signed({2'b00, conc});
    prod = diff * $signed({35'd0, inv_step});
    q = prod >>> 16;
    if (q > 67'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (q < -67'sh8000_0000_0000) return 48'h8000_0000_0000;
    return q[47:0];
  endfunction

  // predict the result of one accepted node
  function void note_node(logic [3:0][31:0] vol, logic [3:0][31:0] conc);
    int lanes;
    logic [33:0] total;
    logic [65:0] wsum;
    logic [65:0] mean;
    logic inter;
    logic [3:0][47:0] rates;
    lanes = (num_mat > 4) ? 4 : num_mat;
    total = 0;
    wsum = 0;
    inter = 0;
    rates = '0;
    for (int i = 0; i < lanes; i++) total += vol[i];
    for (int i = 0; i < lanes; i++)
      if (vol[i] > thresh && {2'b00, vol[i]} != total) inter = 1;
    if (inter) begin
      for (int i = 0; i < lanes; i++) wsum += 66'(vol[i]) * 66'(conc[i]);
      mean = wsum / 66'(total);
      for (int i = 0; i < lanes; i++) rates[i] = lane_rate(mean[31:0], conc[i]);
    end
    pending_rates.push_back({inter, rates});
  endfunction

  // compare one result item with the oldest prediction
  function void check_result(logic inter, logic [3:0][47:0] rates);
    logic [192:0] want;
    if (pending_rates.size() == 0) begin
      $display("%0t: unexpected result item inter=%0d", $time, inter);
      errors++;
      return;
    end
    want = pending_rates.pop_front();
    if (want[192] !== inter) begin
      $display("%0t: is_interface expected %0d actual %0d", $time, want[192], inter);
      errors++;
    end
    for (int i = 0; i < 4; i++)
      if (want[i*48 +: 48] !== rates[i]) begin
        $display("%0t: rate lane %0d expected %h actual %h", $time, i,
                 want[i*48 +: 48], rates[i]);
        errors++;
      end
  endfunction
endclass

module contact_concentration_rate_test;
  import ccr_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [31:0] volume_a, volume_b, volume_c, volume_d;
  logic [31:0] conc_a, conc_b, conc_c, conc_d;
  logic is_interface;
  logic signed [47:0] rate_a, rate_b, rate_c, rate_d;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  rate_scoreboard sb;
  int cycles;
  int burst_left;

  contact_concentration_rate u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .volume_a(volume_a), .volume_b(volume_b), .volume_c(volume_c),
    .volume_d(volume_d), .conc_a(conc_a), .conc_b(conc_b), .conc_c(conc_c),
    .conc_d(conc_d), .out_valid(out_valid), .out_ready(out_ready),
    .is_interface(is_interface), .rate_a(rate_a), .rate_b(rate_b),
    .rate_c(rate_c), .rate_d(rate_d), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("FAIL contact_concentration_rate");
        $finish;
      end
    end
  end

  // receiver: stall pattern and result checking
  initial begin
    int phase;
    out_ready = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(is_interface, {rate_d, rate_c, rate_b, rate_a});
      phase++;
      if (phase % 1000 < 300) out_ready <= 1'b1;
      else if (phase % 1000 < 600) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ((phase / 7) % 3 != 0) && ($urandom_range(0, 1) == 1);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_NUM_MATERIALS: sb.num_mat = val[2:0];
      REG_THRESHOLD: sb.thresh = val;
      default: sb.inv_step = val;
    endcase
    @(posedge clk);
  endtask

  // present one node, after an idle gap between bursts, and wait until it is taken
  task automatic send_node(logic [3:0][31:0] vol, logic [3:0][31:0] conc);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    {volume_d, volume_c, volume_b, volume_a} <= vol;
    {conc_d, conc_c, conc_b, conc_a} <= conc;
    do @(posedge clk); while (!in_ready);
    sb.note_node(vol, conc);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_rates.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_vol();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom_range(0, 1000);
      default: return rand_word();
    endcase
  endfunction

  initial begin
    logic [3:0][31:0] v, c;
    logic [31:0] cfgs[7][3];
    sb = new();
    burst_left = 0;
    rst = 1;
    in_valid = 0;
    cfg_write = 0;
    cfg_index = REG_NUM_MATERIALS;
    cfg_data = 0;
    {volume_d, volume_c, volume_b, volume_a} = '0;
    {conc_d, conc_c, conc_b, conc_a} = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed nodes at reset settings, then with four lanes, then with none
    send_node({32'd0, 32'd0, 32'd0, 32'd0}, '0);
    send_node({32'd0, 32'd0, 32'd5, 32'd5}, {32'd0, 32'd0, 32'h8000_0000, 32'd0});
    send_node({32'd0, 32'd0, 32'd0, 32'd9}, {32'd0, 32'd0, 32'd1, 32'd2});
    send_node({32'd7, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              {32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0});
    send_node({32'd0, 32'd0, 32'd1, 32'd1}, {32'd0, 32'd0, 32'd3, 32'd9});
    drain();
    write_reg(REG_NUM_MATERIALS, 32'd4);
    write_reg(REG_INV_STEP, 32'hFFFF_FFFF);
    write_reg(REG_THRESHOLD, 32'd0);
    send_node({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              {32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0});
    send_node({32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF},
              {32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_node({32'd0, 32'd0, 32'd0, 32'd3}, {32'd1, 32'd2, 32'd3, 32'd4});
    drain();
    write_reg(REG_INV_STEP, 32'd0);
    send_node({32'd3, 32'd1, 32'd2, 32'd4}, {32'd9, 32'd0, 32'hFFFF_FFFF, 32'd5});
    drain();
    write_reg(REG_NUM_MATERIALS, 32'd0);
    write_reg(REG_INV_STEP, 32'd65536);
    send_node({32'd3, 32'd1, 32'd2, 32'd4}, {32'd9, 32'd0, 32'd1, 32'd5});
    drain();

    // random phases over settings: lanes, threshold, inverse step
    cfgs = '{'{7, 0, 32'hFFFF_FFFF}, '{1, 5, 65536}, '{3, 32'hFFFF_FFFF, 1},
             '{4, 100, 32'h0003_0000}, '{5, 0, 32'h8000_0000},
             '{2, 1, 65536}, '{4, 1000, 0}};
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_NUM_MATERIALS, cfgs[p][0]);
      write_reg(REG_THRESHOLD, cfgs[p][1]);
      write_reg(REG_INV_STEP, (p == 1) ? $urandom_range(1, 400000) : cfgs[p][2]);
      for (int n = 0; n < 290; n++) begin
        for (int i = 0; i < 4; i++) begin
          v[i] = rand_vol();
          c[i] = rand_word();
        end
        send_node(v, c);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS contact_concentration_rate");
    end else begin
      $display("FAIL contact_concentration_rate");
    end
    $finish;
  end
endmodule

`default_nettype wire

[contact_concentration_rate.f]
sv/ccr_pkg.sv
sv/ccr_div_step.sv
sv/ccr_rate_lane.sv
sv/contact_concentration_rate.sv
sv/ccr_checker.sv
tb/contact_concentration_rate_test.sv
